@@ src/sfic_pkg.sv @@
package sfic_pkg;

  // Field widths
  localparam int unsigned MeasW  = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned IntW   = 48;
  localparam int unsigned GainW  = 32;
  localparam int unsigned DutyW  = 17;
  localparam int unsigned MulW   = 33;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned SumW   = 51;
  localparam int unsigned CfgIdxW = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegGainCurrent  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegGainVoltage  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegGainIntegral = 8'd2;
  localparam logic [CfgIdxW-1:0] RegHalfStep     = 8'd3;

  // Register reset values
  localparam logic signed [GainW-1:0] GainCurrentRst  = 32'sd3477;
  localparam logic signed [GainW-1:0] GainVoltageRst  = -32'sd2904;
  localparam logic signed [GainW-1:0] GainIntegralRst = -32'sd6463672;
  localparam logic [GainW-1:0]        HalfStepRst     = 32'd21475;

  localparam logic [DutyW-1:0] DutyOne = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_CUR,
    ST_VOLT,
    ST_INT,
    ST_FIN,
    ST_RND,
    ST_CLR
  } state_e;

  typedef enum logic [1:0] {
    MUL_INC,
    MUL_CUR,
    MUL_VOLT,
    MUL_INT
  } mul_sel_e;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_LOAD_NEG,
    SUM_SUB,
    SUM_SUB_SHIFT
  } sum_op_e;

  typedef struct packed {
    logic     load;       // latch the sample fields
    logic     clear;      // zero integral, previous error and duty
    logic     mul_en;     // capture a new product
    mul_sel_e mul_sel;
    logic     int_upd;    // add the increment into the integral
    sum_op_e  sum_op;
    logic     duty_load;  // round, clamp and load the result register
  } cmd_t;

endpackage

@@ src/sfic_ctrl.sv @@
module sfic_ctrl
  import sfic_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_kind_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = in_kind_i ? ST_CLR : ST_INC;
        end
      end
      ST_INC:  state_d = ST_CUR;
      ST_CUR:  state_d = ST_VOLT;
      ST_VOLT: state_d = ST_INT;
      ST_INT:  state_d = ST_FIN;
      ST_FIN:  state_d = ST_RND;
      ST_RND, ST_CLR: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_INC;
    cmd_o.sum_op    = SUM_HOLD;
    unique case (state_q)
      ST_IDLE: cmd_o.load = in_fire;
      ST_INC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_INC;
      end
      ST_CUR: begin
        cmd_o.int_upd = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CUR;
      end
      ST_VOLT: begin
        cmd_o.sum_op  = SUM_LOAD_NEG;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VOLT;
      end
      ST_INT: begin
        cmd_o.sum_op  = SUM_SUB;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_INT;
      end
      ST_FIN: cmd_o.sum_op = SUM_SUB_SHIFT;
      ST_RND: cmd_o.duty_load = out_free;
      ST_CLR: begin
        cmd_o.clear     = out_free;
        cmd_o.duty_load = out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.duty_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/sfic_datapath.sv @@
module sfic_datapath
  import sfic_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  input  logic signed [MeasW-1:0]   cur_i,
  input  logic signed [MeasW-1:0]   volt_i,
  input  logic signed [MeasW-1:0]   ref_i,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [GainW-1:0]          cfg_data_i,
  output logic [DutyW-1:0]          duty_o
);

  logic signed [GainW-1:0] gain_cur_q, gain_volt_q, gain_int_q;
  logic [GainW-1:0]        half_step_q;

  logic signed [MeasW-1:0] cur_q, volt_q;
  logic signed [ErrW-1:0]  err_q, prev_q;
  logic signed [IntW-1:0]  int_q, int_d;
  logic signed [ProdW-1:0] p_q;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [DutyW-1:0]        duty_q, duty_d;

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ErrW:0]    err_pair;
  logic signed [SumW-1:0]  int_sum;
  logic signed [SumW-1:0]  rnd;
  logic signed [SumW-9:0]  rnd_shift;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_cur_q  <= GainCurrentRst;
      gain_volt_q <= GainVoltageRst;
      gain_int_q  <= GainIntegralRst;
      half_step_q <= HalfStepRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegGainCurrent)  gain_cur_q  <= cfg_data_i;
      if (cfg_index_i == RegGainVoltage)  gain_volt_q <= cfg_data_i;
      if (cfg_index_i == RegGainIntegral) gain_int_q  <= cfg_data_i;
      if (cfg_index_i == RegHalfStep)     half_step_q <= cfg_data_i;
    end
  end

  // Shared multiplier operand select
  assign err_pair = (ErrW+1)'(err_q) + (ErrW+1)'(prev_q);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_INC: begin
        mul_a = $signed({1'b0, half_step_q});
        mul_b = MulW'(err_pair);
      end
      MUL_CUR: begin
        mul_a = MulW'(gain_cur_q);
        mul_b = MulW'(cur_q);
      end
      MUL_VOLT: begin
        mul_a = MulW'(gain_volt_q);
        mul_b = MulW'(volt_q);
      end
      MUL_INT: begin
        mul_a = MulW'(gain_int_q);
        mul_b = MulW'($signed(int_q[IntW-1:16]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Saturating integral update
  assign int_sum = SumW'(int_q) + $signed(p_q[SumW-1:0]);

  always_comb begin
    int_d = int_q;
    if (cmd_i.clear) begin
      int_d = '0;
    end else if (cmd_i.int_upd) begin
      if (int_sum[SumW-1:IntW-1] == '0 || int_sum[SumW-1:IntW-1] == '1) begin
        int_d = int_sum[IntW-1:0];
      end else if (int_sum[SumW-1]) begin
        int_d = {1'b1, {(IntW-1){1'b0}}};
      end else begin
        int_d = {1'b0, {(IntW-1){1'b1}}};
      end
    end
  end

  // Command accumulator
  always_comb begin
    unique case (cmd_i.sum_op)
      SUM_HOLD:      sum_d = sum_q;
      SUM_LOAD_NEG:  sum_d = -SumW'($signed(p_q[47:0]));
      SUM_SUB:       sum_d = sum_q - SumW'($signed(p_q[47:0]));
      SUM_SUB_SHIFT: sum_d = sum_q - SumW'($signed(p_q[63:16]));
      default:       sum_d = sum_q;
    endcase
  end

  // Round to Q1.16 and clamp to 0..1
  assign rnd       = sum_q + SumW'(128);
  assign rnd_shift = rnd[SumW-1:8];

  always_comb begin
    if (cmd_i.clear || rnd_shift < 0) begin
      duty_d = '0;
    end else if (rnd_shift > (SumW-8)'(DutyOne)) begin
      duty_d = DutyOne;
    end else begin
      duty_d = rnd_shift[DutyW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q  <= '0;
      prev_q <= '0;
    end else begin
      int_q <= int_d;
      if (cmd_i.clear) begin
        prev_q <= '0;
      end else if (cmd_i.mul_en && cmd_i.mul_sel == MUL_INC) begin
        prev_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q  <= cur_i;
      volt_q <= volt_i;
      err_q  <= ErrW'(ref_i) - ErrW'(volt_i);
    end
    if (cmd_i.mul_en) begin
      p_q <= mul_a * mul_b;
    end
    sum_q <= sum_d;
    if (cmd_i.duty_load) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule

@@ src/state_feedback_integral_controller_unit.sv @@
// Channel   Dir  Signals                          Contents
// s_axis    in   tvalid tready tdata[47:0] tuser  sample: current, voltage, reference; kind
// m_axis    out  tvalid tready tdata[23:0]        duty, Q1.16 clamped to 0..65536
// cfg       in   valid ready index[7:0] data[31:0] gain and half-step registers
//
// A control sample loads its result in ST_RND after ST_INC to ST_FIN: one shared 33x33
// multiplier gives the trapezoid increment and the three feedback terms, one product per
// cycle, then a last subtract and a round/clamp step. A clear loads its zero in ST_CLR.
// s_axis_tready returns the cycle after the load, so new items are taken even while a
// result still waits; a stalled m_axis holds the round/clamp step and the clear.
// Reset (rst_ni low, asynchronous) zeroes the integral and previous error, loads gains.
module state_feedback_integral_controller_unit
  import sfic_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: current_meas[15:0], voltage_meas[31:16], voltage_ref[47:32]
  input  logic [47:0]         s_axis_tdata,
  // tuser: kind[0]
  input  logic                s_axis_tuser,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: duty[16:0], zero fill [23:17]
  output logic [23:0]         m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [GainW-1:0]    cfg_data_i
);

  cmd_t             cmd;
  logic [DutyW-1:0] duty;

  // Configuration is legal only while idle, so take every write at once.
  assign cfg_ready_o = 1'b1;

  sfic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  sfic_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cur_i       ($signed(s_axis_tdata[15:0])),
    .volt_i      ($signed(s_axis_tdata[31:16])),
    .ref_i       ($signed(s_axis_tdata[47:32])),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .duty_o      (duty)
  );

  // Pad the duty field out to whole bytes.
  assign m_axis_tdata = {7'd0, duty};

endmodule

@@ src/sfic_checker.sv @@
module sfic_checker
  import sfic_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Duty never exceeds 1.0 and padding stays zero
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0 && m_axis_tdata[16:0] <= DutyOne)
    else $error("duty out of range");

  // One sample in flight: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // No result appears straight after an accepted item when none was waiting
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind state_feedback_integral_controller_unit sfic_checker u_sfic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_state_feedback_integral_controller_unit.sv @@
module tb_state_feedback_integral_controller_unit;
  import sfic_pkg::*;

  // Run limits and pacing
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned IdlePad    = 4;    // settle cycles before a register write
  localparam int unsigned EndPad     = 16;   // drain cycles after the last result
  localparam int unsigned RandItems  = 1650;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PrintCap   = 200;

  // Item kinds carried on tuser
  localparam logic KindSample = 1'b0;
  localparam logic KindClear  = 1'b1;

  // An index outside the register map; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] RegUnlisted = 8'hFF;

  // Saturation bounds of the 48-bit error integral
  localparam longint IntegMax = (longint'(1) <<< 47) - 1;
  localparam longint IntegMin = -IntegMax - 1;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_CLEAR,
    ROW_CFG
  } row_op_e;

  // One line of the directed stimulus table
  typedef struct packed {
    row_op_e                  op;
    logic [CfgIdxW-1:0]       idx;
    logic [GainW-1:0]         data;
    logic signed [MeasW-1:0]  cur;
    logic signed [MeasW-1:0]  volt;
    logic signed [MeasW-1:0]  sp;
    logic                     typed;   // duty below is known by inspection
    logic [DutyW-1:0]         duty;
  } row_t;

  // DUT connections; every input starts at a known value
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [47:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = KindSample;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [GainW-1:0]    cfg_data_i    = '0;

  // Predictor copy of the register file and the controller state
  logic signed [GainW-1:0] gain_cur  = GainCurrentRst;
  logic signed [GainW-1:0] gain_volt = GainVoltageRst;
  logic signed [GainW-1:0] gain_int  = GainIntegralRst;
  logic [GainW-1:0]        half_step = HalfStepRst;
  longint                  err_integral = 0;
  longint                  last_error   = 0;

  // Duty values still owed by the DUT, oldest first
  logic [DutyW-1:0] pending_duty[$];

  row_t        plan[$];
  int unsigned mismatches  = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt   = 0;
  bit          src_calm    = 1'b0;
  bit          snk_calm    = 1'b0;
  int          rdy_hold    = 0;

  state_feedback_integral_controller_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Gap length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 31);
    if (r < 12) return 0;
    if (r < 30) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Measurement value: extremes, small realistic values, or anything at all
  function automatic logic signed [MeasW-1:0] pick_meas();
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      1, 2, 3: return MeasW'(int'($urandom_range(0, 4095)) - 2048);
      default: return MeasW'($urandom());
    endcase
  endfunction

  // Small signed gain, roughly the scale of the reset gains
  function automatic logic [GainW-1:0] small_gain(int unsigned span);
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  // Advance the controller state by one item and return the duty it yields
  function automatic logic [DutyW-1:0] next_duty(logic kind,
                                                 logic signed [MeasW-1:0] cur,
                                                 logic signed [MeasW-1:0] volt,
                                                 logic signed [MeasW-1:0] sp);
    longint err;
    longint acc;
    longint cmd;
    if (kind == KindClear) begin
      err_integral = 0;
      last_error   = 0;
      return '0;
    end
    err = longint'(sp) - longint'(volt);
    // Trapezoid step: half period times the sum of this and the last error
    acc = err_integral + longint'({32'd0, half_step}) * (err + last_error);
    if (acc > IntegMax) acc = IntegMax;
    else if (acc < IntegMin) acc = IntegMin;
    err_integral = acc;
    last_error   = err;
    // Arithmetic shifts of signed values floor, which the datapath does too
    cmd = -(longint'(gain_cur) * longint'(cur))
          - (longint'(gain_volt) * longint'(volt))
          - ((longint'(gain_int) * (acc >>> 16)) >>> 16);
    cmd = (cmd + 128) >>> 8;
    if (cmd < 0) cmd = 0;
    else if (cmd > longint'(DutyOne)) cmd = longint'(DutyOne);
    return cmd[DutyW-1:0];
  endfunction

  function automatic row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] data);
    row_t row;
    row      = '0;
    row.op   = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  function automatic row_t item_row(row_op_e op, logic signed [MeasW-1:0] cur,
                                    logic signed [MeasW-1:0] volt,
                                    logic signed [MeasW-1:0] sp,
                                    logic typed, logic [DutyW-1:0] duty);
    row_t row;
    row       = '0;
    row.op    = op;
    row.cur   = cur;
    row.volt  = volt;
    row.sp    = sp;
    row.typed = typed;
    row.duty  = duty;
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [DutyW-1:0] got,
                                 logic [DutyW-1:0] want);
    if (mismatches < PrintCap)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    mismatches++;
  endtask

  // Present one item on s_axis, hold it until the transaction completes, then
  // record what it must produce. A typed duty overrides the predictor.
  task automatic send_item(logic kind, logic signed [MeasW-1:0] cur,
                           logic signed [MeasW-1:0] volt,
                           logic signed [MeasW-1:0] sp,
                           logic typed, logic [DutyW-1:0] typed_duty);
    int gap;
    logic [DutyW-1:0] pred;
    if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {sp, volt, cur};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = next_duty(kind, cur, volt, sp);
    pending_duty.push_back(typed ? typed_duty : pred);
  endtask

  // Write one register once the controller has drained. Every item yields a
  // result, so an empty queue plus a short pad means the datapath is idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk_i);
    repeat (IdlePad) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegGainCurrent:  gain_cur  = data;
      RegGainVoltage:  gain_volt = data;
      RegGainIntegral: gain_int  = data;
      RegHalfStep:     half_step = data;
      default: ;  // drop writes outside the map
    endcase
  endtask

  // Result checker and m_axis back-pressure. Sample at the edge, before the
  // DUT's nonblocking updates land, then pick the next tready.
  always @(posedge clk_i) begin
    logic [DutyW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_duty.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[DutyW-1:0], '0);
      end else begin
        want = pending_duty.pop_front();
        if (m_axis_tdata[DutyW-1:0] !== want)
          report_mismatch("duty", m_axis_tdata[DutyW-1:0], want);
      end
      results_seen++;
    end
    // Alternate between calm stretches and stretches with random stalls
    if ($urandom_range(0, 199) == 0) snk_calm = !snk_calm;
    if (rdy_hold != 0) rdy_hold--;
    else if (!snk_calm && $urandom_range(0, 3) == 0) rdy_hold = idle_len();
    m_axis_tready <= (rdy_hold == 0);
  end

  // Watchdog: end the run if the DUT hangs anywhere
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic signed [MeasW-1:0] cur;
    logic signed [MeasW-1:0] volt;
    logic signed [MeasW-1:0] sp;
    int r;
    int v;
    int run_left;

    // Directed table: reset gains first, then saturation and gain extremes
    plan.push_back(item_row(ROW_CLEAR, 16'sh1234, -16'sh0567, 16'sh7ABC, 1'b1, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh8000, 16'sh0000, 16'sh0000, 1'b1, DutyOne));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b1, '0));
    plan.push_back(item_row(ROW_SAMPLE, -16'sh1000, 16'sh0000, 16'sh0000, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0000, 16'sh8000, 16'sh7FFF, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0100, 16'sh0300, 16'sh0320, 1'b0, '0));
    plan.push_back(item_row(ROW_CLEAR, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, '0));
    // Longest half step drives the integral into both rails
    plan.push_back(cfg_row(RegHalfStep, 32'hFFFF_FFFF));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0000, 16'sh8000, 16'sh7FFF, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0000, 16'sh8000, 16'sh7FFF, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0, '0));
    plan.push_back(item_row(ROW_CLEAR, -16'sh0001, -16'sh0001, -16'sh0001, 1'b1, '0));
    // Gains at their limits
    plan.push_back(cfg_row(RegGainCurrent, 32'h7FFF_FFFF));
    plan.push_back(cfg_row(RegGainVoltage, 32'h8000_0000));
    plan.push_back(cfg_row(RegGainIntegral, 32'h8000_0000));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, -16'sh0001, -16'sh0001, -16'sh0001, 1'b0, '0));
    plan.push_back(cfg_row(RegGainIntegral, 32'h7FFF_FFFF));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0000, 16'sh0000, 16'sh7FFF, 1'b0, '0));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0000, 16'sh0000, 16'sh8000, 1'b0, '0));
    plan.push_back(cfg_row(RegHalfStep, 32'h0000_0000));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0064, 16'sh00C8, 16'sh012C, 1'b0, '0));
    // A write outside the map must leave every register alone
    plan.push_back(cfg_row(RegUnlisted, 32'hDEAD_BEEF));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh0064, 16'sh00C8, 16'sh012C, 1'b0, '0));
    // All gains zero: duty is zero whatever the measurements
    plan.push_back(cfg_row(RegGainCurrent, 32'h0000_0000));
    plan.push_back(cfg_row(RegGainVoltage, 32'h0000_0000));
    plan.push_back(cfg_row(RegGainIntegral, 32'h0000_0000));
    plan.push_back(item_row(ROW_SAMPLE, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1, '0));
    plan.push_back(item_row(ROW_CLEAR, 16'sh5A5A, 16'shA5A5, 16'sh0F0F, 1'b1, '0));

    // Hold reset at the start, then release it once
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].op)
        ROW_CFG:    write_reg(plan[i].idx, plan[i].data);
        ROW_CLEAR:  send_item(KindClear, plan[i].cur, plan[i].volt, plan[i].sp,
                              plan[i].typed, plan[i].duty);
        default:    send_item(KindSample, plan[i].cur, plan[i].volt, plan[i].sp,
                              plan[i].typed, plan[i].duty);
      endcase
    end

    // Random phases, each with its own register setting
    run_left = 0;
    sp = '0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          write_reg(RegGainCurrent, GainCurrentRst);
          write_reg(RegGainVoltage, GainVoltageRst);
          write_reg(RegGainIntegral, GainIntegralRst);
          write_reg(RegHalfStep, HalfStepRst);
        end
        1: begin
          write_reg(RegGainCurrent, small_gain(8192));
          write_reg(RegGainVoltage, small_gain(8192));
          write_reg(RegGainIntegral, small_gain(1 << 23));
          write_reg(RegHalfStep, $urandom_range(0, 1 << 20));
        end
        2: begin
          write_reg(RegGainCurrent, $urandom());
          write_reg(RegGainVoltage, $urandom());
          write_reg(RegGainIntegral, $urandom());
          write_reg(RegHalfStep, $urandom());
        end
        3: begin
          write_reg(RegGainCurrent, 32'h7FFF_FFFF);
          write_reg(RegGainVoltage, 32'h8000_0000);
          write_reg(RegGainIntegral, 32'h7FFF_FFFF);
          write_reg(RegHalfStep, 32'hFFFF_FFFF);
        end
        4: begin
          write_reg(RegGainCurrent, 32'h8000_0000);
          write_reg(RegGainVoltage, 32'h7FFF_FFFF);
          write_reg(RegGainIntegral, 32'h8000_0000);
          write_reg(RegHalfStep, 32'h0000_0000);
        end
        default: begin
          write_reg(RegGainCurrent, small_gain(4096));
          write_reg(RegGainVoltage, small_gain(4096));
          write_reg(RegGainIntegral, small_gain(1 << 24));
          write_reg(RegHalfStep, $urandom());
        end
      endcase
      write_reg(CfgIdxW'($urandom_range(int'(RegHalfStep) + 1, 255)), $urandom());

      for (int n = 0; n < RandItems / NumPhases; n++) begin
        // Hold a setpoint for a run of samples, like a regulator in service
        if (run_left == 0) begin
          sp = pick_meas();
          run_left = $urandom_range(10, 80);
        end
        run_left--;
        r = $urandom_range(0, 99);
        if (r < 5) begin
          send_item(KindClear, MeasW'($urandom()), MeasW'($urandom()),
                    MeasW'($urandom()), 1'b0, '0);
        end else if (r < 75) begin
          // Output voltage near the setpoint keeps the integral off the rails
          v = int'(sp) + int'($urandom_range(0, 1023)) - 512;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          volt = v[MeasW-1:0];
          cur = pick_meas();
          send_item(KindSample, cur, volt, sp, 1'b0, '0);
        end else begin
          send_item(KindSample, pick_meas(), pick_meas(), pick_meas(), 1'b0, '0);
        end
      end
    end

    // Drop valid, drain the owed results, then let the pipeline settle
    s_axis_tvalid <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk_i);
    repeat (EndPad) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
